// ===== rtl/ccot_pkg.sv =====
package ccot_pkg;

	localparam int COORD_BITS  = 13;
	localparam int RADIUS_BITS = 10;

	// coordinate difference, squared segment length, t*|d| product, quotient
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int LEN_W  = 2 * COORD_BITS + 1;
	localparam int PROD_W = LEN_W + COORD_BITS;
	localparam int QUOT_W = COORD_BITS;
	localparam int ERR_W  = DIFF_W + 1;
	localparam int RSUM_W = RADIUS_BITS + 1;

	localparam int IN_BITS  = 6 * COORD_BITS + 2 * RADIUS_BITS;
	localparam int IN_TDW   = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDW  = 8;

endpackage

// ===== rtl/ccot_div.sv =====
module ccot_div import ccot_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [PROD_W-1:0]        num,
	input  logic [LEN_W-1:0]         den,
	input  logic                     neg,
	output logic signed [QUOT_W:0]   quot
);

	logic [PROD_W-1:0] rem_s [0:QUOT_W];
	logic [QUOT_W-1:0] q_s   [0:QUOT_W];
	logic [LEN_W-1:0]  den_s [0:QUOT_W];
	logic              neg_s [0:QUOT_W];

	assign rem_s[0] = num;
	assign q_s[0]   = '0;
	assign den_s[0] = den;
	assign neg_s[0] = neg;

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		localparam int SH = QUOT_W - 1 - k;
		logic [PROD_W-1:0] dsh;
		logic              ge;
		assign dsh = PROD_W'(den_s[k]) << SH;
		assign ge  = rem_s[k] >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? rem_s[k] - dsh : rem_s[k];
				q_s[k+1]   <= {q_s[k][QUOT_W-2:0], ge};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// truncation toward zero: apply the sign to the magnitude quotient
	assign quot = neg_s[QUOT_W] ? -$signed({1'b0, q_s[QUOT_W]}) : $signed({1'b0, q_s[QUOT_W]});

endmodule

// ===== rtl/circle_capsule_overlap_test_core.sv =====
// Circle versus circle / circle versus capsule overlap test.
// Pipeline from input transaction to result: 4 front stages,
// 13 restoring divider stages, 3 back stages. One item per cycle while the
// output is not stalled; the rate is set by the pipelined dividers, one quotient bit per stage.
// Reset (arst_n low, asynchronous) clears all valid bits; payload is not reset.
module circle_capsule_overlap_test_core import ccot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// a_x, a_y, a_r, b_x1, b_y1, b_x2, b_y2, b_r (lowest bits first), zero fill
	input  logic [IN_TDW-1:0]  s_tdata,
	// func
	input  logic               s_tuser,
	output logic               m_tvalid,
	input  logic               m_tready,
	// hit, zero fill
	output logic [OUT_TDW-1:0] m_tdata
);

	localparam int CB = COORD_BITS;
	localparam int RB = RADIUS_BITS;

	// Unpack the input transaction.
	logic [CB-1:0] a_x, a_y, b_x1, b_y1, b_x2, b_y2;
	logic [RB-1:0] a_r, b_r;
	logic          func;

	assign a_x  = s_tdata[0*CB +: CB];
	assign a_y  = s_tdata[1*CB +: CB];
	assign a_r  = s_tdata[2*CB +: RB];
	assign b_x1 = s_tdata[2*CB + RB +: CB];
	assign b_y1 = s_tdata[3*CB + RB +: CB];
	assign b_x2 = s_tdata[4*CB + RB +: CB];
	assign b_y2 = s_tdata[5*CB + RB +: CB];
	assign b_r  = s_tdata[6*CB + RB +: RB];
	assign func = s_tuser;

	// Whole pipeline advances together; hold everything while the result waits.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: coordinate differences and radius sum.
	logic                     v_s1, func_s1;
	logic signed [DIFF_W-1:0] sx_s1, sy_s1, dxa_s1, dya_s1;
	logic [RSUM_W-1:0]        rs_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			sx_s1   <= $signed({b_x2[CB-1], b_x2}) - $signed({b_x1[CB-1], b_x1});
			sy_s1   <= $signed({b_y2[CB-1], b_y2}) - $signed({b_y1[CB-1], b_y1});
			dxa_s1  <= $signed({a_x[CB-1], a_x}) - $signed({b_x1[CB-1], b_x1});
			dya_s1  <= $signed({a_y[CB-1], a_y}) - $signed({b_y1[CB-1], b_y1});
			rs_s1   <= RSUM_W'(a_r) + RSUM_W'(b_r);
		end
	end

	// Stage 2: squared segment terms and projection dot terms.
	logic                       v_s2, func_s2, negx_s2, negy_s2;
	logic signed [2*DIFF_W-1:0] sxx_s2, syy_s2, tx_s2, ty_s2;
	logic signed [DIFF_W-1:0]   dxa_s2, dya_s2;
	logic [CB-1:0]              absx_s2, absy_s2;
	logic [RSUM_W-1:0]          rs_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			sxx_s2  <= sx_s1 * sx_s1;
			syy_s2  <= sy_s1 * sy_s1;
			tx_s2   <= dxa_s1 * sx_s1;
			ty_s2   <= dya_s1 * sy_s1;
			negx_s2 <= sx_s1[DIFF_W-1];
			negy_s2 <= sy_s1[DIFF_W-1];
			absx_s2 <= CB'(sx_s1[DIFF_W-1] ? -sx_s1 : sx_s1);
			absy_s2 <= CB'(sy_s1[DIFF_W-1] ? -sy_s1 : sy_s1);
			dxa_s2  <= dxa_s1;
			dya_s2  <= dya_s1;
			rs_s2   <= rs_s1;
		end
	end

	// Stage 3: squared length, dot product, clamp to 0..len2.
	logic                       v_s3, use_s3, negx_s3, negy_s3;
	logic [LEN_W-1:0]           len_s3, tc_s3;
	logic signed [DIFF_W-1:0]   dxa_s3, dya_s3;
	logic [CB-1:0]              absx_s3, absy_s3;
	logic [RSUM_W-1:0]          rs_s3;
	logic [LEN_W-1:0]           len_w, tc_w;
	logic signed [2*DIFF_W:0]   t_w;

	assign len_w   = LEN_W'(sxx_s2 + syy_s2);
	assign t_w     = (2*DIFF_W+1)'(tx_s2) + (2*DIFF_W+1)'(ty_s2);

	always_comb begin
		if (t_w < 0)
			tc_w = '0;
		else if (t_w > $signed({{(2*DIFF_W+1-LEN_W){1'b0}}, len_w}))
			tc_w = len_w;
		else
			tc_w = t_w[LEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			use_s3  <= func_s2 && (len_w != '0);
			len_s3  <= len_w;
			tc_s3   <= tc_w;
			negx_s3 <= negx_s2;
			negy_s3 <= negy_s2;
			absx_s3 <= absx_s2;
			absy_s3 <= absy_s2;
			dxa_s3  <= dxa_s2;
			dya_s3  <= dya_s2;
			rs_s3   <= rs_s2;
		end
	end

	// Stage 4: numerators t*|sx| and t*|sy|.
	logic                     v_s4, use_s4, negx_s4, negy_s4;
	logic [PROD_W-1:0]        nx_s4, ny_s4;
	logic [LEN_W-1:0]         len_s4;
	logic signed [DIFF_W-1:0] dxa_s4, dya_s4;
	logic [RSUM_W-1:0]        rs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			use_s4  <= use_s3;
			nx_s4   <= PROD_W'(tc_s3) * PROD_W'(absx_s3);
			ny_s4   <= PROD_W'(tc_s3) * PROD_W'(absy_s3);
			len_s4  <= len_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			dxa_s4  <= dxa_s3;
			dya_s4  <= dya_s3;
			rs_s4   <= rs_s3;
		end
	end

	// Divider stages: closest-point offsets per axis.
	logic signed [QUOT_W:0] qx, qy;

	ccot_div u_div_x (
		.clk  (clk),
		.en   (en),
		.num  (nx_s4),
		.den  (len_s4),
		.neg  (negx_s4),
		.quot (qx)
	);

	ccot_div u_div_y (
		.clk  (clk),
		.en   (en),
		.num  (ny_s4),
		.den  (len_s4),
		.neg  (negy_s4),
		.quot (qy)
	);

	// Side data travels alongside the divider stages.
	logic                     v_sd   [0:QUOT_W-1];
	logic                     use_sd [0:QUOT_W-1];
	logic signed [DIFF_W-1:0] dxa_sd [0:QUOT_W-1];
	logic signed [DIFF_W-1:0] dya_sd [0:QUOT_W-1];
	logic [RSUM_W-1:0]        rs_sd  [0:QUOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUOT_W; i++) v_sd[i] <= 1'b0;
		end else if (en) begin
			v_sd[0] <= v_s4;
			for (int i = 1; i < QUOT_W; i++) v_sd[i] <= v_sd[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			use_sd[0] <= use_s4;
			dxa_sd[0] <= dxa_s4;
			dya_sd[0] <= dya_s4;
			rs_sd[0]  <= rs_s4;
			for (int i = 1; i < QUOT_W; i++) begin
				use_sd[i] <= use_sd[i-1];
				dxa_sd[i] <= dxa_sd[i-1];
				dya_sd[i] <= dya_sd[i-1];
				rs_sd[i]  <= rs_sd[i-1];
			end
		end
	end

	// Stage 5: error vector from closest point to circle centre.
	logic                    v_s5;
	logic signed [ERR_W-1:0] ex_s5, ey_s5;
	logic [RSUM_W-1:0]       rs_s5;
	logic signed [ERR_W-1:0] offx_w, offy_w;

	// zero-length segment or circle test: closest point is the start point
	assign offx_w = use_sd[QUOT_W-1] ? ERR_W'(qx) : '0;
	assign offy_w = use_sd[QUOT_W-1] ? ERR_W'(qy) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_sd[QUOT_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ex_s5 <= ERR_W'(dxa_sd[QUOT_W-1]) - offx_w;
			ey_s5 <= ERR_W'(dya_sd[QUOT_W-1]) - offy_w;
			rs_s5 <= rs_sd[QUOT_W-1];
		end
	end

	// Stage 6: squares.
	logic                      v_s6;
	logic signed [2*ERR_W-1:0] exx_s6, eyy_s6;
	logic [2*RSUM_W-1:0]       rr_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			exx_s6 <= ex_s5 * ex_s5;
			eyy_s6 <= ey_s5 * ey_s5;
			rr_s6  <= (2*RSUM_W)'(rs_s5) * (2*RSUM_W)'(rs_s5);
		end
	end

	// Stage 7: strict compare, output register.
	logic               hit_s7;
	logic [2*ERR_W:0]   d2_w;

	assign d2_w = (2*ERR_W+1)'($unsigned(exx_s6)) + (2*ERR_W+1)'($unsigned(eyy_s6));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (en) m_tvalid <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) hit_s7 <= d2_w < (2*ERR_W+1)'(rr_s6);
	end

	assign m_tdata = {{(OUT_TDW-1){1'b0}}, hit_s7};

endmodule
